// ----- hw/rtl/hpc_pkg.sv -----
// Package for the half precision converter: op codes and conversion functions.
// No dependencies.
package hpc_pkg;

  localparam int OpW = 2;
  localparam int DataW = 64;

  localparam logic [OpW-1:0] OP_S2H = 2'd0;
  localparam logic [OpW-1:0] OP_D2H = 2'd1;
  localparam logic [OpW-1:0] OP_H2S = 2'd2;
  localparam logic [OpW-1:0] OP_H2D = 2'd3;

  localparam logic [15:0] HALF_INF   = 16'h7C00;
  localparam logic [15:0] HALF_NAN   = 16'hFE00;
  localparam logic [31:0] SGL_NAN    = 32'hFFC00000;
  localparam logic [31:0] DBL_NAN_HI = 32'hFFF80000;

  // single (dbl=0) or double upper word (dbl=1) to half
  function automatic logic [15:0] narrow(input logic [31:0] x, input logic dbl);
    logic [15:0] sgn;
    logic [10:0] e;
    logic        emax;
    logic [22:0] m;
    logic [23:0] full;
    logic signed [12:0] he;
    logic [5:0]  sh;
    logic [5:0]  mb;
    logic [15:0] hm;
    logic        rb;
    sgn = {x[31], 15'd0};
    if (dbl) begin
      e = x[30:20];
      emax = &x[30:20];
      m = {3'd0, x[19:0]};
      mb = 6'd20;
      he = $signed({2'b00, e}) - 13'sd1008;
    end else begin
      e = {3'd0, x[30:23]};
      emax = &x[30:23];
      m = x[22:0];
      mb = 6'd23;
      he = $signed({2'b00, e}) - 13'sd112;
    end
    full = dbl ? {3'd0, 1'b1, x[19:0]} : {1'b1, x[22:0]};
    hm = 16'd0;
    rb = 1'b0;
    sh = 6'd0;
    if (e == 11'd0) begin
      narrow = sgn;
    end else if (emax) begin
      narrow = (m == 23'd0) ? (sgn | HALF_INF) : HALF_NAN;
    end else if (he >= 13'sd31) begin
      narrow = sgn | HALF_INF;
    end else if (he <= 13'sd0) begin
      // he is at least -1008 here only for doubles; clamp large shifts
      if (he < -13'sd20) begin
        narrow = sgn;
      end else begin
        sh = mb - 6'd9 + 6'(-he);
        if (sh > mb + 6'd1) begin
          narrow = sgn;
        end else begin
          hm = 16'(full >> sh);
          rb = full[5'(sh - 6'd1)];
          narrow = sgn | (hm + {15'd0, rb});
        end
      end
    end else begin
      if (dbl) begin
        hm = {1'b0, he[4:0], x[19:10]};
        rb = x[9];
      end else begin
        hm = {1'b0, he[4:0], x[22:13]};
        rb = x[12];
      end
      narrow = sgn | (hm + {15'd0, rb});
    end
  endfunction

  // half to single (dbl=0) or double upper word (dbl=1)
  function automatic logic [31:0] widen(input logic [15:0] h, input logic dbl);
    logic [31:0] sgn;
    logic [4:0]  he;
    logic [9:0]  hm;
    logic [3:0]  lz;
    logic [9:0]  nm;
    logic [10:0] ex;
    sgn = {h[15], 31'd0};
    he = h[14:10];
    hm = h[9:0];
    lz = 4'd0;
    for (int i = 0; i <= 9; i++) begin
      if (hm[i]) lz = 4'(9 - i);
    end
    nm = hm << (lz + 4'd1);
    if (h[14:0] == 15'd0) begin
      widen = sgn;
    end else if (he == 5'd31) begin
      if (hm != 10'd0) widen = dbl ? DBL_NAN_HI : SGL_NAN;
      else widen = dbl ? (sgn | 32'h7FF00000) : (sgn | 32'h7F800000);
    end else if (he == 5'd0) begin
      ex = (dbl ? 11'd1008 : 11'd112) - {7'd0, lz};
      widen = dbl ? (sgn | {1'b0, ex, nm, 10'd0}) : (sgn | {1'b0, ex[7:0], nm, 13'd0});
    end else begin
      ex = (dbl ? 11'd1008 : 11'd112) + {6'd0, he};
      widen = dbl ? (sgn | {1'b0, ex, hm, 10'd0}) : (sgn | {1'b0, ex[7:0], hm, 13'd0});
    end
  endfunction

endpackage

// ----- hw/rtl/half_precision_converter.sv -----
// Top level of the half precision converter.
// Depends on hpc_pkg for op codes and the conversion functions.
//
// channel  ports                               handshake
// input    in_op, in_operand_bits, in_last_in  start & !busy
// result   out_result_bits, out_last_out       out_valid, one cycle
//
// One item per cycle; start passes through the input register, then the conversion
// logic feeds the result register that drives out_valid.
// busy is always low: the pipeline never stalls and the receiver cannot.
// Synchronous active-low reset clears the valid flags only.
module half_precision_converter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [hpc_pkg::OpW-1:0]   in_op,
  input  logic [hpc_pkg::DataW-1:0] in_operand_bits,
  input  logic                      in_last_in,
  output logic                      out_valid,
  output logic [hpc_pkg::DataW-1:0] out_result_bits,
  output logic                      out_last_out
);
  import hpc_pkg::*;

  logic          s1_vld_r;
  logic [OpW-1:0] s1_op_r;
  logic [DataW-1:0] s1_bits_r;
  logic          s1_last_r;
  logic [DataW-1:0] res_nxt;
  logic [DataW-1:0] res_r;
  logic          vld_r;
  logic          last_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      vld_r    <= 1'b0;
    end else begin
      s1_vld_r <= start;
      vld_r    <= s1_vld_r;
    end
  end

  // payload beats, no reset needed
  always_ff @(posedge clk) begin
    s1_op_r   <= in_op;
    s1_bits_r <= in_operand_bits;
    s1_last_r <= in_last_in;
    res_r     <= res_nxt;
    last_r    <= s1_last_r;
  end

  always_comb begin
    case (s1_op_r)
      OP_S2H:  res_nxt = DataW'(narrow(s1_bits_r[31:0], 1'b0));
      OP_D2H:  res_nxt = DataW'(narrow(s1_bits_r[63:32], 1'b1));
      OP_H2S:  res_nxt = DataW'(widen(s1_bits_r[15:0], 1'b0));
      default: res_nxt = {widen(s1_bits_r[15:0], 1'b1), 32'd0};
    endcase
  end

  assign out_valid       = vld_r;
  assign out_result_bits = res_r;
  assign out_last_out    = last_r;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ##1 out_valid) else $error("result lost");
  a_nov: assert property (@(posedge clk) disable iff (!rst_n)
    !start |=> ##1 !out_valid) else $error("spurious result");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ##1 (out_last_out == $past(in_last_in, 2))) else $error("last mismatch");
endmodule

// ----- bench/tb_half_precision_converter.sv -----
// Self-checking bench for half_precision_converter: IEEE half <-> single/double.
// Depends on hpc_pkg (op codes) and the half_precision_converter RTL.
// Expected values come from a local bit-level conversion model in the scoreboard.
`timescale 1ns / 1ps

module tb_half_precision_converter;
  import hpc_pkg::*;

  // Holds expected conversion results in issue order and checks each output beat.
  class conv_scoreboard;
    logic [63:0] exp_bits_q[$];
    logic        exp_last_q[$];
    int          mismatches = 0;

    // narrowing of a 32-bit word; ebits/mbits give the source layout
    function automatic logic [15:0] to_half(logic [31:0] x, int ebits, int mbits, int bias);
      logic [31:0] sgn, emax, e, m, full, hm;
      int he, sh;
      sgn = (x >> 16) & 32'h8000;
      emax = (32'd1 << ebits) - 1;
      e = (x >> mbits) & emax;
      m = x & ((32'd1 << mbits) - 1);
      if (x[30:0] == 0 || e == 0) return sgn[15:0];
      if (e == emax) return (m == 0) ? (sgn[15:0] | 16'h7C00) : 16'hFE00;
      he = int'(e) - bias + 15;
      if (he >= 31) return sgn[15:0] | 16'h7C00;
      full = m | (32'd1 << mbits);
      if (he <= 0) begin
        sh = mbits - 9 - he;
        if (sh > mbits + 1) return sgn[15:0];
        hm = full >> sh;
        if ((full >> (sh - 1)) & 1) hm = hm + 1;
        return 16'(sgn | hm);
      end
      sh = mbits - 10;
      hm = (32'(he) << 10) | (m >> sh);
      if ((m >> (sh - 1)) & 1) hm = hm + 1;
      return 16'(sgn | hm);
    endfunction

    function automatic logic [31:0] from_half(logic [15:0] h, int ebits, int mbits,
                                              int bias, logic [31:0] nan_word);
      logic [31:0] sgn, he, hm, emax;
      int extra;
      sgn = {h[15], 31'd0};
      he = {27'd0, h[14:10]};
      hm = {22'd0, h[9:0]};
      emax = (32'd1 << ebits) - 1;
      extra = 0;
      if (h[14:0] == 0) return sgn;
      if (he == 31) return (hm == 0) ? (sgn | (emax << mbits)) : nan_word;
      if (he == 0) begin
        hm = hm << 1;
        while (!hm[10] && extra < 10) begin
          hm = hm << 1;
          extra++;
        end
        hm = hm & 32'h3FF;
        return sgn | (32'(bias - 15 - extra) << mbits) | (hm << (mbits - 10));
      end
      return sgn | (32'(int'(he) + bias - 15) << mbits) | (hm << (mbits - 10));
    endfunction

    function void note_beat(logic [1:0] op, logic [63:0] v, logic last);
      logic [63:0] r;
      case (op)
        OP_S2H: r = {48'd0, to_half(v[31:0], 8, 23, 127)};
        OP_D2H: r = {48'd0, to_half(v[63:32], 11, 20, 1023)};
        OP_H2S: r = {32'd0, from_half(v[15:0], 8, 23, 127, SGL_NAN)};
        default: r = {from_half(v[15:0], 11, 20, 1023, DBL_NAN_HI), 32'd0};
      endcase
      exp_bits_q = {exp_bits_q, r};
      exp_last_q = {exp_last_q, last};
    endfunction

    function void check_beat(logic [63:0] bits, logic last);
      logic [63:0] eb;
      logic el;
      if (exp_bits_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h last=%0b", bits, last);
        return;
      end
      eb = exp_bits_q.pop_front();
      el = exp_last_q.pop_front();
      if (eb !== bits || el !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h last=%0b, got %h last=%0b", eb, el, bits, last);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  in_op = '0;
  logic [63:0] in_operand_bits = '0;
  logic        in_last_in = 0;
  logic        out_valid;
  logic [63:0] out_result_bits;
  logic        out_last_out;

  conv_scoreboard sb = new();

  half_precision_converter DUT (
    .clk, .rst_n, .start, .busy, .in_op, .in_operand_bits, .in_last_in,
    .out_valid, .out_result_bits, .out_last_out
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // result side: receiver cannot stall, so sample every rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_beat(out_result_bits, out_last_out);
  end

  // one beat: hold start until accepted at a rising edge, then lower it at the
  // next falling edge unless another beat follows right away (no gap).
  task automatic send_beat(logic [1:0] op, logic [63:0] v, logic last);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;  // stretches of back-to-back beats
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(negedge clk);
    end
    start <= 1;
    in_op <= op;
    in_operand_bits <= v;
    in_last_in <= last;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_beat(op, v, last);
    @(negedge clk);
  endtask

  // random 64-bit word biased toward interesting exponent regions
  function automatic logic [63:0] pick_operand(logic [1:0] op);
    logic [63:0] v;
    int k;
    v = {$urandom, $urandom};
    k = $urandom_range(0, 5);
    case (op)
      OP_S2H: begin
        if (k == 0) v[30:23] = 8'(($urandom_range(0, 40)) + 90);   // subnormal/underflow band
        else if (k == 1) v[30:23] = 8'(($urandom_range(0, 40)) + 110);
        else if (k == 2) v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else if (k == 3) v[30:23] = 8'(($urandom_range(0, 8)) + 139);
      end
      OP_D2H: begin
        if (k == 0) v[62:52] = 11'(($urandom_range(0, 40)) + 970);
        else if (k == 1) v[62:52] = 11'(($urandom_range(0, 40)) + 990);
        else if (k == 2) v[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
        else if (k == 3) v[62:52] = 11'(($urandom_range(0, 8)) + 1035);
      end
      default: begin
        if (k == 0) v[14:10] = 5'd0;
        else if (k == 1) v[14:10] = 5'd31;
      end
    endcase
    return v;
  endfunction

  // directed corners: zeros, inf, nan, subnormals, overflow, rounding carries
  logic [1:0]  dir_op[$];
  logic [63:0] dir_val[$];

  initial begin
    int n;
    dir_op = '{OP_S2H, OP_S2H, OP_S2H, OP_S2H, OP_S2H, OP_S2H, OP_S2H, OP_S2H,
               OP_D2H, OP_D2H, OP_D2H, OP_D2H, OP_D2H, OP_D2H,
               OP_H2S, OP_H2S, OP_H2S, OP_H2S, OP_H2S,
               OP_H2D, OP_H2D, OP_H2D, OP_H2D, OP_H2D};
    dir_val = '{64'h0, 64'hFFFFFFFF_80000000, 64'h7F800000, 64'hFF800001,
                64'h00000001, 64'h477FF000, 64'h387FE000, 64'h33000000,
                64'h80000000_00000000, 64'h7FF00000_00000000, 64'h7FF00000_00000001,
                64'h40EFFE00_FFFFFFFF, 64'hBF0FFC00_00000000, 64'h00000001_FFFFFFFF,
                64'hFFFFFFFF_FFFF8000, 64'h7C00, 64'hFC01, 64'h0001, 64'h83FF,
                64'h0000, 64'hFC00, 64'h7E00, 64'h0200, 64'h7BFF};
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    foreach (dir_op[i]) send_beat(dir_op[i], dir_val[i], i[0]);
    // hold off until everything has drained once
    start <= 0;
    while (sb.exp_bits_q.size() != 0) @(negedge clk);
    for (n = 0; n < 1750; n++) begin
      logic [1:0] op;
      op = 2'($urandom_range(0, 3));
      send_beat(op, pick_operand(op), 1'($urandom_range(0, 1)));
    end
    start <= 0;
    while (sb.exp_bits_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (sb.mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #200000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/hpc_pkg.sv
hw/rtl/half_precision_converter.sv
bench/tb_half_precision_converter.sv
